// ----- rtl/core/gwf_pkg.sv -----
// gwf_pkg: constants, codes, types and helpers for the grid wall follower walker
// no dependencies; imported by gwf_probe, grid_wall_follower_walker and the bench
`timescale 1ns / 1ps

package gwf_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COUNT_BITS = 4;

  localparam int X_BITS    = $clog2(MAX_WIDTH);
  localparam int Y_BITS    = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS = X_BITS + Y_BITS;
  localparam int CELL_BITS = COUNT_BITS + 1;
  localparam int NX_BITS   = X_BITS + 1;
  localparam int NY_BITS   = Y_BITS + 1;
  localparam int GRID_BITS = 7;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 7;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;

  // item modes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_STEP = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // headings
  localparam logic [1:0] HEAD_EAST  = 2'd0;
  localparam logic [1:0] HEAD_NORTH = 2'd1;
  localparam logic [1:0] HEAD_WEST  = 2'd2;
  localparam logic [1:0] HEAD_SOUTH = 2'd3;

  // relative turns
  localparam logic [1:0] TURN_AHEAD = 2'd0;
  localparam logic [1:0] TURN_LEFT  = 2'd1;
  localparam logic [1:0] TURN_BACK  = 2'd2;
  localparam logic [1:0] TURN_RIGHT = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_X       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_Y       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_HEADING = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_FOLLOW_RIGHT  = 3'd5;

  typedef struct packed {
    logic [X_BITS-1:0] x;
    logic [Y_BITS-1:0] y;
    logic [1:0]        dir;
    logic              in_grid;
  } probe_t;

  function automatic logic cell_in_grid(input logic [NX_BITS-1:0] x,
                                        input logic [NY_BITS-1:0] y,
                                        input logic [GRID_BITS-1:0] gw,
                                        input logic [GRID_BITS-1:0] gh);
    logic ok;
    ok = ({1'b0, x} < {1'b0, gw}) && (x < NX_BITS'(MAX_WIDTH)) &&
         ({1'b0, y} < {1'b0, gh}) && (y < NY_BITS'(MAX_HEIGHT));
    return ok;
  endfunction

endpackage

// ----- rtl/core/grid_wall_follower_walker.sv -----
// grid_wall_follower_walker: wall-following grid walker, cell store in one sync ram
// depends on gwf_pkg and gwf_probe
// a load or an unused mode goes straight to S_FIN, a read waits in S_RD for the
//   ram data, a step reads its own cell in S_CUR, then each candidate takes S_PROBE and,
//   if in the grid, a ram read checked in S_CHECK; S_FIN waits for a free output register
// one item at a time; next one taken once the result is registered, even with out_tready low
// reset (rst_n low, synchronous): control idle, registers to defaults, walker
//   at start; cell store is not cleared, unwritten cells are undefined
`timescale 1ns / 1ps

module grid_wall_follower_walker
  import gwf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_TDATA_W-1:0]    in_tdata,   // cell_x[5:0], cell_y[11:6], is_wall[12]
  input  logic [IN_TUSER_W-1:0]    in_tuser,   // mode[1:0]
  // result stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_TDATA_W-1:0]   out_tdata,  // walker_x[5:0], walker_y[11:6],
                                               // walker_heading[13:12], pass_count[17:14],
                                               // at_start[18], moved[19]
  // configuration writes
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CUR,
    S_PROBE,
    S_CHECK,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [GRID_BITS-1:0] grid_width_r, grid_width_nxt;
  logic [GRID_BITS-1:0] grid_height_r, grid_height_nxt;
  logic [X_BITS-1:0]    start_x_r, start_x_nxt;
  logic [Y_BITS-1:0]    start_y_r, start_y_nxt;
  logic [1:0]           start_heading_r, start_heading_nxt;
  logic                 follow_right_r, follow_right_nxt;

  // walker state
  logic [X_BITS-1:0]    col_r, col_nxt;
  logic [Y_BITS-1:0]    row_r, row_nxt;
  logic [1:0]           heading_r, heading_nxt;

  // per-item working registers
  logic [1:0]            mode_r, mode_nxt;
  logic [1:0]            idx_r, idx_nxt;
  logic                  cur_wall_r, cur_wall_nxt;
  logic [COUNT_BITS-1:0] cur_cnt_r, cur_cnt_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  moved_r, moved_nxt;
  logic [X_BITS-1:0]     pnx_r, pnx_nxt;
  logic [Y_BITS-1:0]     pny_r, pny_nxt;
  logic [1:0]            pdir_r, pdir_nxt;

  // output register
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // cell store: bit 0 wall, counter above
  logic [CELL_BITS-1:0] cell_mem [2**ADDR_BITS];
  logic [CELL_BITS-1:0] rdata_r;
  logic                 mem_we, mem_re;
  logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
  logic [CELL_BITS-1:0] mem_wdata;

  // input fields
  logic [1:0]          in_mode;
  logic [X_BITS-1:0]   in_cell_x;
  logic [Y_BITS-1:0]   in_cell_y;
  logic                in_is_wall;

  probe_t               probe;
  logic [ADDR_BITS-1:0] cur_addr;
  logic                 cur_in_grid;
  logic                 at_start;
  logic [COUNT_BITS-1:0] cnt_sat;

  assign in_mode    = in_tuser[1:0];
  assign in_cell_x  = in_tdata[5:0];
  assign in_cell_y  = in_tdata[11:6];
  assign in_is_wall = in_tdata[12];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign cur_addr    = {row_r, col_r};
  assign cur_in_grid = cell_in_grid({1'b0, col_r}, {1'b0, row_r}, grid_width_r, grid_height_r);
  assign at_start    = (col_r == start_x_r) && (row_r == start_y_r);
  // counter of the cell being left, saturating
  assign cnt_sat     = (cur_cnt_r == '1) ? cur_cnt_r : cur_cnt_r + COUNT_BITS'(1);

  // neighbor of the candidate move selected by idx_r
  gwf_probe u_probe (
    .col          (col_r),
    .row          (row_r),
    .heading      (heading_r),
    .idx          (idx_r),
    .follow_right (follow_right_r),
    .grid_width   (grid_width_r),
    .grid_height  (grid_height_r),
    .probe        (probe)
  );

  always_comb begin
    state_nxt         = state_r;
    grid_width_nxt    = grid_width_r;
    grid_height_nxt   = grid_height_r;
    start_x_nxt       = start_x_r;
    start_y_nxt       = start_y_r;
    start_heading_nxt = start_heading_r;
    follow_right_nxt  = follow_right_r;
    col_nxt           = col_r;
    row_nxt           = row_r;
    heading_nxt       = heading_r;
    mode_nxt          = mode_r;
    idx_nxt           = idx_r;
    cur_wall_nxt      = cur_wall_r;
    cur_cnt_nxt       = cur_cnt_r;
    cnt_nxt           = cnt_r;
    moved_nxt         = moved_r;
    pnx_nxt           = pnx_r;
    pny_nxt           = pny_r;
    pdir_nxt          = pdir_r;
    out_tvalid_nxt    = out_tvalid_r && !out_tready;
    out_tdata_nxt     = out_tdata_r;
    mem_we            = 1'b0;
    mem_waddr         = cur_addr;
    mem_wdata         = '0;
    mem_re            = 1'b0;
    mem_raddr         = cur_addr;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_mode;
          cnt_nxt   = '0;
          moved_nxt = 1'b0;
          idx_nxt   = '0;
          case (in_mode)
            MODE_LOAD: begin
              // a load writes the wall bit and clears the counter
              mem_we    = 1'b1;
              mem_waddr = {in_cell_y, in_cell_x};
              mem_wdata = {{COUNT_BITS{1'b0}}, in_is_wall};
              state_nxt = S_FIN;
            end
            MODE_READ: begin
              mem_re    = 1'b1;
              mem_raddr = {in_cell_y, in_cell_x};
              state_nxt = S_RD;
            end
            MODE_STEP: begin
              // fetch the cell being stood on for its wall bit and counter
              mem_re    = 1'b1;
              mem_raddr = cur_addr;
              state_nxt = S_CUR;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_RD: begin
        cnt_nxt   = rdata_r[CELL_BITS-1:1];
        state_nxt = S_FIN;
      end

      S_CUR: begin
        cur_wall_nxt = !cur_in_grid || rdata_r[0];
        cur_cnt_nxt  = rdata_r[CELL_BITS-1:1];
        state_nxt    = S_PROBE;
      end

      S_PROBE: begin
        pnx_nxt  = probe.x;
        pny_nxt  = probe.y;
        pdir_nxt = probe.dir;
        if (probe.in_grid) begin
          mem_re    = 1'b1;
          mem_raddr = {probe.y, probe.x};
          state_nxt = S_CHECK;
        end else if (idx_r == 2'd3) begin
          // boxed in: turn around and stay
          heading_nxt = heading_r + TURN_BACK;
          state_nxt   = S_FIN;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end

      S_CHECK: begin
        if (!rdata_r[0]) begin
          // free neighbor: count the cell left and move
          if (!cur_wall_r) begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr;
            mem_wdata = {cnt_sat, 1'b0};
          end
          col_nxt     = pnx_r;
          row_nxt     = pny_r;
          heading_nxt = pdir_r;
          moved_nxt   = 1'b1;
          state_nxt   = S_FIN;
        end else if (idx_r == 2'd3) begin
          heading_nxt = heading_r + TURN_BACK;
          state_nxt   = S_FIN;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_PROBE;
        end
      end

      S_FIN: begin
        // hand the result to the output register once it is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {4'b0000, moved_r, at_start, cnt_r, heading_r, row_r, col_r};
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // configuration writes must arrive only while idle; the block itself does not enforce this
    if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width_nxt  = cfg_wdata[GRID_BITS-1:0];
        REG_GRID_HEIGHT: grid_height_nxt = cfg_wdata[GRID_BITS-1:0];
        REG_START_X: begin
          start_x_nxt = cfg_wdata[X_BITS-1:0];
          col_nxt     = cfg_wdata[X_BITS-1:0];
        end
        REG_START_Y: begin
          start_y_nxt = cfg_wdata[Y_BITS-1:0];
          row_nxt     = cfg_wdata[Y_BITS-1:0];
        end
        REG_START_HEADING: begin
          start_heading_nxt = cfg_wdata[1:0];
          heading_nxt       = cfg_wdata[1:0];
        end
        REG_FOLLOW_RIGHT: follow_right_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      grid_width_r    <= GRID_BITS'(MAX_WIDTH);
      grid_height_r   <= GRID_BITS'(MAX_HEIGHT);
      start_x_r       <= '0;
      start_y_r       <= '0;
      start_heading_r <= HEAD_EAST;
      follow_right_r  <= 1'b0;
      col_r           <= '0;
      row_r           <= '0;
      heading_r       <= HEAD_EAST;
      mode_r          <= MODE_LOAD;
      idx_r           <= '0;
      cnt_r           <= '0;
      moved_r         <= 1'b0;
      out_tvalid_r    <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      grid_width_r    <= grid_width_nxt;
      grid_height_r   <= grid_height_nxt;
      start_x_r       <= start_x_nxt;
      start_y_r       <= start_y_nxt;
      start_heading_r <= start_heading_nxt;
      follow_right_r  <= follow_right_nxt;
      col_r           <= col_nxt;
      row_r           <= row_nxt;
      heading_r       <= heading_nxt;
      mode_r          <= mode_nxt;
      idx_r           <= idx_nxt;
      cnt_r           <= cnt_nxt;
      moved_r         <= moved_nxt;
      out_tvalid_r    <= out_tvalid_nxt;
    end
    cur_wall_r  <= cur_wall_nxt;
    cur_cnt_r   <= cur_cnt_nxt;
    pnx_r       <= pnx_nxt;
    pny_r       <= pny_nxt;
    pdir_r      <= pdir_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // single-port cell ram, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= cell_mem[mem_raddr];
    end
  end

  // a neighbor check always follows a probe issue
  a_check_after_probe : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> ($past(state_r) == S_PROBE))
    else $error("neighbor check without a probe");

  // a non-read item always reports a zero counter
  a_count_only_on_read : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && mode_r != MODE_READ) |-> (cnt_r == '0))
    else $error("pass count set on a non-read item");

  // a counter write during a step only leaves an open cell
  a_count_open_cell : assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_CHECK) |-> (!cur_wall_r && !rdata_r[0]))
    else $error("counter written for a wall cell or a blocked move");

  // last candidate out of the grid ends the step
  a_boxed_in_ends : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && idx_r == 2'd3 && !probe.in_grid) |=> (state_r == S_FIN))
    else $error("step did not end after the last candidate");

endmodule

// ----- rtl/core/gwf_probe.sv -----
// gwf_probe: neighbor cell for one candidate move of the wall follower
// depends on gwf_pkg (probe_t, cell_in_grid, heading and turn codes)
`timescale 1ns / 1ps

module gwf_probe
  import gwf_pkg::*;
(
  input  logic [X_BITS-1:0]    col,
  input  logic [Y_BITS-1:0]    row,
  input  logic [1:0]           heading,
  input  logic [1:0]           idx,
  input  logic                 follow_right,
  input  logic [GRID_BITS-1:0] grid_width,
  input  logic [GRID_BITS-1:0] grid_height,
  output probe_t               probe
);

  logic [1:0]         side;
  logic [1:0]         turn;
  logic [1:0]         dir;
  logic [NX_BITS-1:0] nx;
  logic [NY_BITS-1:0] ny;
  logic               below_edge;

  // try order: preferred side, ahead, other side, back
  always_comb begin
    side = follow_right ? TURN_RIGHT : TURN_LEFT;
    case (idx)
      2'd0:    turn = side;
      2'd1:    turn = TURN_AHEAD;
      2'd2:    turn = side ^ TURN_BACK;
      default: turn = TURN_BACK;
    endcase
    dir = heading + turn;
  end

  always_comb begin
    nx = {1'b0, col};
    ny = {1'b0, row};
    below_edge = 1'b0;
    case (dir)
      HEAD_EAST:  nx = {1'b0, col} + NX_BITS'(1);
      HEAD_NORTH: begin
        below_edge = (row == '0);
        ny = {1'b0, row} - NY_BITS'(1);
      end
      HEAD_WEST: begin
        below_edge = (col == '0);
        nx = {1'b0, col} - NX_BITS'(1);
      end
      default:    ny = {1'b0, row} + NY_BITS'(1);
    endcase
    probe.x       = nx[X_BITS-1:0];
    probe.y       = ny[Y_BITS-1:0];
    probe.dir     = dir;
    probe.in_grid = !below_edge && cell_in_grid(nx, ny, grid_width, grid_height);
  end

endmodule

// ----- bench/grid_wall_follower_walker_test.sv -----
// self-checking bench for grid_wall_follower_walker: directed mazes, then random
// maze phases with random stream stalls, checked against an in-bench walker model
// depends on gwf_pkg and the rtl of grid_wall_follower_walker
`timescale 1ns / 1ps

module grid_wall_follower_walker_test;
  import gwf_pkg::*;

  localparam int          ITEM_TARGET   = 1650;
  localparam int          IDLE_PCT      = 37;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          LIMIT_CYCLES  = 400000;
  localparam int          CELLS         = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;    // answered with the walker pose, no move and no count

  // one input transaction
  typedef struct packed {
    logic [1:0]        mode;
    logic [X_BITS-1:0] x;
    logic [Y_BITS-1:0] y;
    logic              wall;
  } cell_req_t;

  // one result transaction
  typedef struct packed {
    logic [X_BITS-1:0]     x;
    logic [Y_BITS-1:0]     y;
    logic [1:0]            dir;
    logic [COUNT_BITS-1:0] passes;
    logic                  at_start;
    logic                  moved;
  } walk_report_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_TDATA_W-1:0]    in_tdata = '0;    // cell_x[5:0], cell_y[11:6], is_wall[12]
  logic [IN_TUSER_W-1:0]    in_tuser = '0;    // mode[1:0]
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   out_tdata;        // walker_x[5:0], walker_y[11:6],
                                              // walker_heading[13:12], pass_count[17:14],
                                              // at_start[18], moved[19]
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  grid_wall_follower_walker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial forever #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // walker model: maze, pass counters, walker pose and register copies
  // ---------------------------------------------------------------------------
  logic                  cell_wall   [CELLS];
  logic [COUNT_BITS-1:0] cell_passes [CELLS];
  logic [GRID_BITS-1:0]  grid_w = 7'd64;
  logic [GRID_BITS-1:0]  grid_h = 7'd64;
  logic [X_BITS-1:0]     home_x = '0;
  logic [Y_BITS-1:0]     home_y = '0;
  logic [1:0]            home_dir = HEAD_EAST;
  logic                  right_hand = 1'b0;
  logic [X_BITS-1:0]     pos_x = '0;
  logic [Y_BITS-1:0]     pos_y = '0;
  logic [1:0]            pos_dir = HEAD_EAST;

  walk_report_t report_q [$];    // expected results, oldest first
  cell_req_t    pending_q [$];   // items waiting for the driver

  int  queued_total, accepted_total, results_total, fails;
  int  n_items, n_phases, n_loads, n_steps, n_moves, n_boxed, n_reads, n_sat;
  bit  steady;                   // no stalls on either side while set

  // off the grid or off the low edges counts as wall
  function automatic bit is_blocked(input int x, input int y);
    if (x < 0 || y < 0 || x >= int'(grid_w) || y >= int'(grid_h) ||
        x >= MAX_WIDTH || y >= MAX_HEIGHT)
      return 1'b1;
    return cell_wall[y * MAX_WIDTH + x];
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] val);
    case (idx)
      REG_GRID_WIDTH:    grid_w = val;
      REG_GRID_HEIGHT:   grid_h = val;
      REG_START_X: begin
        home_x = val[X_BITS-1:0];
        pos_x  = home_x;
      end
      REG_START_Y: begin
        home_y = val[Y_BITS-1:0];
        pos_y  = home_y;
      end
      REG_START_HEADING: begin
        home_dir = val[1:0];
        pos_dir  = home_dir;
      end
      REG_FOLLOW_RIGHT:  right_hand = val[0];
      default: ;
    endcase
  endfunction

  // wall-follower move plus load/read handling, returns the expected report
  function automatic walk_report_t walk_item(input cell_req_t it);
    walk_report_t r;
    logic [1:0]   turns [4];
    logic [1:0]   d;
    int           dx, dy, cx, cy, a;
    bit           went;
    r = '0;
    a = int'(it.y) * MAX_WIDTH + int'(it.x);
    case (it.mode)
      MODE_LOAD: begin
        cell_wall[a]   = it.wall;
        cell_passes[a] = '0;
        n_loads++;
      end
      MODE_STEP: begin
        cx   = int'(pos_x);
        cy   = int'(pos_y);
        went = 1'b0;
        // preferred side, ahead, other side, back
        turns[0] = right_hand ? TURN_RIGHT : TURN_LEFT;
        turns[1] = TURN_AHEAD;
        turns[2] = turns[0] ^ TURN_BACK;
        turns[3] = TURN_BACK;
        for (int i = 0; i < 4 && !went; i++) begin
          d  = pos_dir + turns[i];
          dx = 0;
          dy = 0;
          case (d)
            HEAD_EAST:  dx = 1;
            HEAD_NORTH: dy = -1;
            HEAD_WEST:  dx = -1;
            default:    dy = 1;
          endcase
          if (!is_blocked(cx + dx, cy + dy)) begin
            // only a free in-grid cell counts when left
            if (!is_blocked(cx, cy) &&
                cell_passes[cy * MAX_WIDTH + cx] != {COUNT_BITS{1'b1}})
              cell_passes[cy * MAX_WIDTH + cx]++;
            pos_x   = X_BITS'(cx + dx);
            pos_y   = Y_BITS'(cy + dy);
            pos_dir = d;
            went    = 1'b1;
          end
        end
        // boxed in on all four sides: turn around in place
        if (!went) begin
          pos_dir = pos_dir + TURN_BACK;
          n_boxed++;
        end
        r.moved = went;
        n_steps++;
        if (went) n_moves++;
      end
      MODE_READ: begin
        r.passes = cell_passes[a];
        n_reads++;
        if (r.passes == {COUNT_BITS{1'b1}}) n_sat++;
      end
      default: ;
    endcase
    r.x        = pos_x;
    r.y        = pos_y;
    r.dir      = pos_dir;
    r.at_start = (pos_x == home_x) && (pos_y == home_y);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: pulls items from the pending queue, models each accepted transaction
  // ---------------------------------------------------------------------------
  cell_req_t drive_item;

  always @(posedge clk) begin : driver
    cell_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        report_q.push_back(walk_item(drive_item));
        accepted_total++;
      end
      // hold the current item until it is taken, then drive a new item or idle at random
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_q.pop_front();
          drive_item <= nxt;
          in_tdata   <= IN_TDATA_W'({nxt.wall, nxt.y, nxt.x});
          in_tuser   <= nxt.mode;
          in_tvalid  <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random backpressure, compare each result with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : monitor
    walk_report_t want, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{x: out_tdata[5:0], y: out_tdata[11:6], dir: out_tdata[13:12],
                passes: out_tdata[17:14], at_start: out_tdata[18], moved: out_tdata[19]};
        results_total++;
        if (report_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fails++;
        end else begin
          want = report_q.pop_front();
          check_field("walker_x", int'(want.x), int'(got.x));
          check_field("walker_y", int'(want.y), int'(got.y));
          check_field("walker_heading", int'(want.dir), int'(got.dir));
          check_field("pass_count", int'(want.passes), int'(got.passes));
          check_field("at_start", int'(want.at_start), int'(got.at_start));
          check_field("moved", int'(want.moved), int'(got.moved));
        end
      end
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog
  int cycles;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, report_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: which cells have been loaded, so no unwritten cell is ever read
  // ---------------------------------------------------------------------------
  bit loaded_map [CELLS];
  int loaded_list [$];

  task automatic add_item(input logic [1:0] mode, input int x, input int y, input bit wall);
    cell_req_t it;
    it = '{mode: mode, x: X_BITS'(x), y: Y_BITS'(y), wall: wall};
    pending_q.push_back(it);
    queued_total++;
    if (mode != MODE_UNUSED) n_items++;
  endtask

  task automatic load_cell(input int x, input int y, input bit wall);
    add_item(MODE_LOAD, x, y, wall);
    if (!loaded_map[y * MAX_WIDTH + x]) begin
      loaded_map[y * MAX_WIDTH + x] = 1'b1;
      loaded_list.push_back(y * MAX_WIDTH + x);
    end
  endtask

  // load the whole active grid, or only its never-written cells; ~30% walls
  task automatic fill_grid(input bit fresh);
    for (int y = 0; y < int'(grid_h); y++)
      for (int x = 0; x < int'(grid_w); x++)
        if (fresh || !loaded_map[y * MAX_WIDTH + x])
          load_cell(x, y, $urandom_range(0, 9) < 3);
  endtask

  // write one register while the block is idle; model follows at once
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_BITS'(val);
    apply_reg(idx, CFG_DATA_BITS'(val));
  endtask

  task automatic cfg_done();
    @(posedge clk);
    cfg_we <= 1'b0;
    n_phases++;
  endtask

  // every item taken and answered, then let the block settle
  task automatic wait_idle();
    while (accepted_total != queued_total || report_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int w, h, body, sel, a;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-cell grid: walker boxed in, heading flips; far corner loaded and read
    write_reg(REG_GRID_WIDTH, 1);
    write_reg(REG_GRID_HEIGHT, 1);
    write_reg(REG_START_X, 0);
    write_reg(REG_START_Y, 0);
    write_reg(REG_START_HEADING, int'(HEAD_SOUTH));
    write_reg(REG_FOLLOW_RIGHT, 0);
    cfg_done();
    load_cell(0, 0, 1'b0);
    load_cell(63, 63, 1'b1);
    load_cell(63, 0, 1'b0);
    add_item(MODE_STEP, 0, 0, 1'b0);
    add_item(MODE_STEP, 0, 0, 1'b0);
    add_item(MODE_READ, 0, 0, 1'b0);
    add_item(MODE_READ, 63, 63, 1'b0);
    add_item(MODE_UNUSED, 21, 42, 1'b1);
    wait_idle();

    // 2x1 corridor, right hand: walker bounces and counts on both cells
    write_reg(REG_GRID_WIDTH, 2);
    write_reg(REG_START_X, 1);
    write_reg(REG_START_HEADING, int'(HEAD_WEST));
    write_reg(REG_FOLLOW_RIGHT, 1);
    cfg_done();
    load_cell(0, 0, 1'b0);
    load_cell(1, 0, 1'b0);
    repeat (4) add_item(MODE_STEP, 0, 0, 1'b0);
    add_item(MODE_READ, 1, 0, 1'b0);
    wait_idle();

    // start outside the grid: walker steps in without counting its start cell
    write_reg(REG_GRID_HEIGHT, 2);
    write_reg(REG_START_X, 2);
    write_reg(REG_START_Y, 1);
    write_reg(REG_START_HEADING, int'(HEAD_NORTH));
    write_reg(REG_FOLLOW_RIGHT, 0);
    cfg_done();
    load_cell(0, 1, 1'b1);
    load_cell(1, 1, 1'b0);
    repeat (3) add_item(MODE_STEP, 0, 0, 1'b0);
    add_item(MODE_READ, 0, 0, 1'b0);

    // random maze phases, one with no stalls at all
    for (int phase = 0; n_items < ITEM_TARGET; phase++) begin
      wait_idle();
      steady = (phase == 6);
      sel = $urandom_range(0, 9);
      case (sel)
        0: begin w = 64; h = 1;  end
        1: begin w = 1;  h = 64; end
        2: begin w = 1;  h = 1;  end
        default: begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 8);
        end
      endcase
      write_reg(REG_GRID_WIDTH, w);
      write_reg(REG_GRID_HEIGHT, h);
      // start mostly inside, sometimes anywhere; sometimes left as it was
      if ($urandom_range(0, 9) < 7)
        write_reg(REG_START_X, $urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                         : $urandom_range(0, w - 1));
      if ($urandom_range(0, 9) < 7)
        write_reg(REG_START_Y, $urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                         : $urandom_range(0, h - 1));
      if ($urandom_range(0, 9) < 7) write_reg(REG_START_HEADING, $urandom_range(0, 3));
      if ($urandom_range(0, 9) < 7) write_reg(REG_FOLLOW_RIGHT, $urandom_range(0, 1));
      cfg_done();
      fill_grid(w * h <= 64 && $urandom_range(0, 1) == 1);

      body = $urandom_range(20, 60);
      repeat (body) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          add_item(MODE_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                   1'($urandom_range(0, 1)));
        end else if (sel < 75) begin
          // read a cell of the grid, or any cell loaded so far
          if ($urandom_range(0, 9) < 7) begin
            add_item(MODE_READ, $urandom_range(0, w - 1), $urandom_range(0, h - 1), 1'b0);
          end else begin
            a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            add_item(MODE_READ, a % MAX_WIDTH, a / MAX_WIDTH, 1'($urandom_range(0, 1)));
          end
        end else if (sel < 92) begin
          // reshape the maze under the walker
          load_cell($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                    $urandom_range(0, 9) < 3);
        end else if (sel < 97) begin
          load_cell($urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom_range(0, 1)));
        end else begin
          add_item(MODE_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                   1'($urandom_range(0, 1)));
        end
      end
    end

    steady = 1'b0;
    wait_idle();
    $display("covered %0d register phases: %0d loads, %0d steps (%0d moves, %0d boxed in)",
             n_phases, n_loads, n_steps, n_moves, n_boxed);
    $display("%0d counter reads (%0d saturated), %0d results checked, %0d mismatches",
             n_reads, n_sat, results_total, fails);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
